@@ src/acps_pkg.sv @@
// ----------------------------------------------------------------------------
// acps_pkg
// Types, pair codes and geometry tables of the anode-cathode pair selector.
// ----------------------------------------------------------------------------
package acps_pkg;

    localparam int WIRE_W  = 6;
    localparam int HS_W    = 7;
    localparam int FIRST_W = 3;
    localparam int SECOND_W = 2;
    localparam int CODE_W  = 4;

    // first_pair codes
    localparam logic [FIRST_W-1:0] FIRST_NONE = 3'd0;
    localparam logic [FIRST_W-1:0] FIRST_BB   = 3'd1;
    localparam logic [FIRST_W-1:0] FIRST_BS   = 3'd2;
    localparam logic [FIRST_W-1:0] FIRST_SB   = 3'd3;
    localparam logic [FIRST_W-1:0] FIRST_SS   = 3'd4;

    // second_pair codes
    localparam logic [SECOND_W-1:0] SECOND_NONE = 2'd0;
    localparam logic [SECOND_W-1:0] SECOND_BS   = 2'd1;
    localparam logic [SECOND_W-1:0] SECOND_SB   = 2'd2;
    localparam logic [SECOND_W-1:0] SECOND_SS   = 2'd3;

    // region codes
    localparam logic REGION_1A = 1'b0;
    localparam logic REGION_1B = 1'b1;

    typedef struct packed {
        logic            present;
        logic [HS_W-1:0] lo;
        logic [HS_W-1:0] hi;
    } hs_range_t;

    typedef struct packed {
        logic [FIRST_W-1:0]  first;
        logic [SECOND_W-1:0] second;
    } choice_t;

    function automatic hs_range_t mk_range(input int lo, input int hi);
        hs_range_t r;
        r.present = 1'b1;
        r.lo      = HS_W'(lo);
        r.hi      = HS_W'(hi);
        return r;
    endfunction

    // Inclusive half-strip range a wire group can cross, per region.
    function automatic hs_range_t wire_range(input logic region,
                                             input logic [WIRE_W-1:0] wg);
        hs_range_t r;
        r = '0;
        if (region == REGION_1A) begin
            case (wg)
                6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5,
                6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11: r = mk_range(0, 95);
                6'd12:   r = mk_range(0, 77);
                6'd13:   r = mk_range(0, 61);
                6'd14:   r = mk_range(0, 39);
                6'd15:   r = mk_range(0, 22);
                default: r = '0;
            endcase
        end
        else begin
            if (wg >= 6'd14 && wg <= 6'd43) begin
                r = mk_range(0, 127);
            end
            else begin
                case (wg)
                    6'd10:   r = mk_range(100, 127);
                    6'd11:   r = mk_range(73, 127);
                    6'd12:   r = mk_range(47, 127);
                    6'd13:   r = mk_range(22, 127);
                    6'd44:   r = mk_range(0, 105);
                    6'd45:   r = mk_range(0, 93);
                    6'd46:   r = mk_range(0, 78);
                    6'd47:   r = mk_range(0, 63);
                    default: r = '0;
                endcase
            end
        end
        return r;
    endfunction

    // Crossing code (bb, bs, sb, ss) to chosen pairs.
    function automatic choice_t pick(input logic [CODE_W-1:0] code);
        choice_t c;
        case (code)
            4'd0:    c = '{FIRST_NONE, SECOND_NONE};
            4'd1:    c = '{FIRST_SS,   SECOND_NONE};
            4'd2:    c = '{FIRST_SB,   SECOND_NONE};
            4'd3:    c = '{FIRST_SB,   SECOND_SS};
            4'd4:    c = '{FIRST_BS,   SECOND_NONE};
            4'd5:    c = '{FIRST_BS,   SECOND_SS};
            4'd6:    c = '{FIRST_BS,   SECOND_SB};
            4'd7:    c = '{FIRST_BS,   SECOND_SB};
            4'd8:    c = '{FIRST_BB,   SECOND_NONE};
            4'd9:    c = '{FIRST_BB,   SECOND_SS};
            4'd10:   c = '{FIRST_BB,   SECOND_SB};
            4'd11:   c = '{FIRST_BB,   SECOND_SS};
            4'd12:   c = '{FIRST_BB,   SECOND_BS};
            4'd13:   c = '{FIRST_BB,   SECOND_SS};
            4'd14:   c = '{FIRST_BB,   SECOND_BS};
            4'd15:   c = '{FIRST_BB,   SECOND_SS};
            default: c = '{FIRST_NONE, SECOND_NONE};
        endcase
        return c;
    endfunction

endpackage

@@ src/acps_cross.sv @@
// ----------------------------------------------------------------------------
// acps_cross
// Crossing test of one anode-cathode pair against the region's range table.
// ----------------------------------------------------------------------------
module acps_cross
(
    input  logic                        region,
    input  logic                        anode_valid,
    input  logic [acps_pkg::WIRE_W-1:0] wire_group,
    input  logic                        cathode_valid,
    input  logic [acps_pkg::HS_W-1:0]   halfstrip,
    output logic                        hit
);

    acps_pkg::hs_range_t rng;

    assign rng = acps_pkg::wire_range(region, wire_group);
    assign hit = anode_valid && cathode_valid && rng.present
                 && (halfstrip >= rng.lo) && (halfstrip <= rng.hi);

endmodule

@@ src/anode_cathode_pair_selector.sv @@
// ----------------------------------------------------------------------------
// anode_cathode_pair_selector
// Pick the crossing anode-cathode pairs of one candidate set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_ready) carries one candidate word: the
//   region, two anode candidates and two cathode candidates, each second one
//   with a duplicate flag. Output channel (result_valid / result_ready)
//   carries one result word: first_pair, second_pair and cross_bits.
//   The word is held in an input register, then the four crossing tests and
//   the choice table run in one combinational pass into the result register.
//   Throughput: one word per clock; the input register and the result
//   register form a two-deep pipeline, so a new word is taken every cycle
//   as long as the result side keeps draining.
//   Stall: when result_ready is low, the result word holds; the input stage
//   still fills once, then item_ready drops until the result is taken.
//   Reset: both stages empty, no result valid; the block holds no state
//   between words and needs no setup.
// ----------------------------------------------------------------------------
module anode_cathode_pair_selector
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          region,
    input  logic                          best_anode_valid,
    input  logic [acps_pkg::WIRE_W-1:0]   best_anode_wire,
    input  logic                          second_anode_valid,
    input  logic [acps_pkg::WIRE_W-1:0]   second_anode_wire,
    input  logic                          second_anode_duplicate,
    input  logic                          best_cathode_valid,
    input  logic [acps_pkg::HS_W-1:0]     best_cathode_halfstrip,
    input  logic                          second_cathode_valid,
    input  logic [acps_pkg::HS_W-1:0]     second_cathode_halfstrip,
    input  logic                          second_cathode_duplicate,

    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [acps_pkg::FIRST_W-1:0]  first_pair,
    output logic [acps_pkg::SECOND_W-1:0] second_pair,
    output logic [acps_pkg::CODE_W-1:0]   cross_bits
);

    // ------------------------------------------------------------------
    // Input stage: hold the accepted word. Fold the duplicate flags into
    // the valid bits right away, so the crossing tests see plain valids.
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic                        region_reg;
    logic                        ba_reg;
    logic [acps_pkg::WIRE_W-1:0] bw_reg;
    logic                        sa_reg;
    logic [acps_pkg::WIRE_W-1:0] sw_reg;
    logic                        bc_reg;
    logic [acps_pkg::HS_W-1:0]   bh_reg;
    logic                        sc_reg;
    logic [acps_pkg::HS_W-1:0]   sh_reg;

    logic                        out_valid_reg;
    logic [acps_pkg::FIRST_W-1:0]  first_reg;
    logic [acps_pkg::SECOND_W-1:0] second_reg;
    logic [acps_pkg::CODE_W-1:0]   code_reg;

    logic                        out_free;
    logic                        stage_move;
    logic                        take;
    logic [acps_pkg::CODE_W-1:0] code_next;
    acps_pkg::choice_t           choice_next;

    // Result register frees when empty or drained this cycle.
    assign out_free   = !out_valid_reg || result_ready;
    assign stage_move = in_valid_reg && out_free;
    assign item_ready = !in_valid_reg || out_free;
    assign take       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (take) begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_move) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            region_reg <= region;
            ba_reg     <= best_anode_valid;
            bw_reg     <= best_anode_wire;
            sa_reg     <= second_anode_valid && !second_anode_duplicate;
            sw_reg     <= second_anode_wire;
            bc_reg     <= best_cathode_valid;
            bh_reg     <= best_cathode_halfstrip;
            sc_reg     <= second_cathode_valid && !second_cathode_duplicate;
            sh_reg     <= second_cathode_halfstrip;
        end
    end

    // ------------------------------------------------------------------
    // Crossing tests: bb, bs, sb, ss (bit 3 down to bit 0).
    // ------------------------------------------------------------------
    acps_cross u_cross_bb
    (
        .region        (region_reg),
        .anode_valid   (ba_reg),
        .wire_group    (bw_reg),
        .cathode_valid (bc_reg),
        .halfstrip     (bh_reg),
        .hit           (code_next[3])
    );

    acps_cross u_cross_bs
    (
        .region        (region_reg),
        .anode_valid   (ba_reg),
        .wire_group    (bw_reg),
        .cathode_valid (sc_reg),
        .halfstrip     (sh_reg),
        .hit           (code_next[2])
    );

    acps_cross u_cross_sb
    (
        .region        (region_reg),
        .anode_valid   (sa_reg),
        .wire_group    (sw_reg),
        .cathode_valid (bc_reg),
        .halfstrip     (bh_reg),
        .hit           (code_next[1])
    );

    acps_cross u_cross_ss
    (
        .region        (region_reg),
        .anode_valid   (sa_reg),
        .wire_group    (sw_reg),
        .cathode_valid (sc_reg),
        .halfstrip     (sh_reg),
        .hit           (code_next[0])
    );

    assign choice_next = acps_pkg::pick(code_next);

    // ------------------------------------------------------------------
    // Result stage: advance when the result side is free, else hold.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_move) begin
            first_reg  <= choice_next.first;
            second_reg <= choice_next.second;
            code_reg   <= code_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign first_pair   = first_reg;
    assign second_pair  = second_reg;
    assign cross_bits   = code_reg;

endmodule

@@ src/acps_checker.sv @@
// ----------------------------------------------------------------------------
// acps_checker
// Port-level checks of the pair selector, bound to the top level.
// ----------------------------------------------------------------------------
module acps_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [acps_pkg::FIRST_W-1:0]  first_pair,
    input  logic [acps_pkg::SECOND_W-1:0] second_pair,
    input  logic [acps_pkg::CODE_W-1:0]   cross_bits
);

    // Hold a stalled result word.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
        && $stable(first_pair) && $stable(second_pair) && $stable(cross_bits))
        else $error("result word changed while stalled");

    // No crossing means no pair chosen.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && cross_bits == '0 |->
        first_pair == acps_pkg::FIRST_NONE && second_pair == acps_pkg::SECOND_NONE)
        else $error("pair chosen without crossing");

    // A best-best crossing always wins the first slot.
    a_bb_first: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && cross_bits[3] |-> first_pair == acps_pkg::FIRST_BB)
        else $error("best-best crossing not chosen first");

    // A second pair needs at least two crossings.
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && second_pair != acps_pkg::SECOND_NONE |->
        $countones(cross_bits) >= 2)
        else $error("second pair chosen with fewer than two crossings");

endmodule

bind anode_cathode_pair_selector acps_checker u_acps_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .first_pair   (first_pair),
    .second_pair  (second_pair),
    .cross_bits   (cross_bits)
);

@@ bench/tb_anode_cathode_pair_selector.sv @@
// ----------------------------------------------------------------------------
// tb_anode_cathode_pair_selector
// Self-checking bench for the anode-cathode pair selector.
// Drives candidate words through the valid/ready input channel, predicts the
// crossing bits and the chosen pairs of each accepted word, and compares
// every result word field by field in arrival order. Directed words hit the
// range edges of both regions, the duplicate flags and the wire groups that
// have no range. Random words then mix geometry-aware candidate sets with
// raw noise under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_anode_cathode_pair_selector;

    localparam int RANDOM_WORDS = 1550;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT = 18;
    // Idle tail run after the last result has come back, before the summary.
    localparam int TAIL_CYCLES = 8;

    // One candidate word as it travels on the input channel.
    typedef struct {
        logic                        region;
        logic                        best_anode_valid;
        logic [acps_pkg::WIRE_W-1:0] best_anode_wire;
        logic                        second_anode_valid;
        logic [acps_pkg::WIRE_W-1:0] second_anode_wire;
        logic                        second_anode_duplicate;
        logic                        best_cathode_valid;
        logic [acps_pkg::HS_W-1:0]   best_cathode_halfstrip;
        logic                        second_cathode_valid;
        logic [acps_pkg::HS_W-1:0]   second_cathode_halfstrip;
        logic                        second_cathode_duplicate;
    } cand_word_t;

    // One result word: the chosen pairs and the crossing flags behind them.
    typedef struct {
        logic [acps_pkg::FIRST_W-1:0]  first;
        logic [acps_pkg::SECOND_W-1:0] second;
        logic [acps_pkg::CODE_W-1:0]   flags;
    } pair_choice_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the pair choice of each accepted word and checks
    // the result words against the oldest pending prediction.
    // ------------------------------------------------------------------------
    class pair_scoreboard;
        pair_choice_t pending_q[$];
        int           errors;
        int           checked;
        bit [15:0]    codes_seen;

        // Inclusive half-strip window of a wire group; 0 when it has none.
        static function bit hs_window(logic rgn, logic [acps_pkg::WIRE_W-1:0] wg,
                                      output int lo, output int hi);
            lo = 0;
            hi = 127;
            if (rgn == acps_pkg::REGION_1A) begin
                if (wg < 12)
                    hi = 95;
                else if (wg == 12)
                    hi = 77;
                else if (wg == 13)
                    hi = 61;
                else if (wg == 14)
                    hi = 39;
                else if (wg == 15)
                    hi = 22;
                else
                    return 1'b0;
            end
            else begin
                case (wg)
                    6'd10: lo = 100;
                    6'd11: lo = 73;
                    6'd12: lo = 47;
                    6'd13: lo = 22;
                    6'd44: hi = 105;
                    6'd45: hi = 93;
                    6'd46: hi = 78;
                    6'd47: hi = 63;
                    default:
                        if (wg < 14 || wg > 47)
                            return 1'b0;
                endcase
            end
            return 1'b1;
        endfunction

        static function bit pair_crosses(logic rgn, logic anode_ok,
                                         logic [acps_pkg::WIRE_W-1:0] wg,
                                         logic cathode_ok,
                                         logic [acps_pkg::HS_W-1:0] hs);
            int lo;
            int hi;
            if (!anode_ok || !cathode_ok)
                return 1'b0;
            if (!hs_window(rgn, wg, lo, hi))
                return 1'b0;
            return (int'(hs) >= lo) && (int'(hs) <= hi);
        endfunction

        static function pair_choice_t choose_pairs(cand_word_t w);
            pair_choice_t c;
            logic         sa;
            logic         sc;
            // A second candidate flagged as duplicate drops out.
            sa = w.second_anode_valid && !w.second_anode_duplicate;
            sc = w.second_cathode_valid && !w.second_cathode_duplicate;
            c.flags[3] = pair_crosses(w.region, w.best_anode_valid, w.best_anode_wire,
                                      w.best_cathode_valid, w.best_cathode_halfstrip);
            c.flags[2] = pair_crosses(w.region, w.best_anode_valid, w.best_anode_wire,
                                      sc, w.second_cathode_halfstrip);
            c.flags[1] = pair_crosses(w.region, sa, w.second_anode_wire,
                                      w.best_cathode_valid, w.best_cathode_halfstrip);
            c.flags[0] = pair_crosses(w.region, sa, w.second_anode_wire,
                                      sc, w.second_cathode_halfstrip);
            case (c.flags)
                4'd0:
                begin
                    c.first = acps_pkg::FIRST_NONE; c.second = acps_pkg::SECOND_NONE;
                end
                4'd1:
                begin
                    c.first = acps_pkg::FIRST_SS;   c.second = acps_pkg::SECOND_NONE;
                end
                4'd2:
                begin
                    c.first = acps_pkg::FIRST_SB;   c.second = acps_pkg::SECOND_NONE;
                end
                4'd3:
                begin
                    c.first = acps_pkg::FIRST_SB;   c.second = acps_pkg::SECOND_SS;
                end
                4'd4:
                begin
                    c.first = acps_pkg::FIRST_BS;   c.second = acps_pkg::SECOND_NONE;
                end
                4'd5:
                begin
                    c.first = acps_pkg::FIRST_BS;   c.second = acps_pkg::SECOND_SS;
                end
                4'd6, 4'd7:
                begin
                    c.first = acps_pkg::FIRST_BS;   c.second = acps_pkg::SECOND_SB;
                end
                4'd8:
                begin
                    c.first = acps_pkg::FIRST_BB;   c.second = acps_pkg::SECOND_NONE;
                end
                4'd9:
                begin
                    c.first = acps_pkg::FIRST_BB;   c.second = acps_pkg::SECOND_SS;
                end
                4'd10:
                begin
                    c.first = acps_pkg::FIRST_BB;   c.second = acps_pkg::SECOND_SB;
                end
                4'd12, 4'd14:
                begin
                    c.first = acps_pkg::FIRST_BB;   c.second = acps_pkg::SECOND_BS;
                end
                default:
                begin
                    c.first = acps_pkg::FIRST_BB;   c.second = acps_pkg::SECOND_SS;
                end
            endcase
            return c;
        endfunction

        function void note_word(cand_word_t w);
            pending_q = {pending_q, choose_pairs(w)};
        endfunction

        function void check_result(logic [acps_pkg::FIRST_W-1:0] first,
                                   logic [acps_pkg::SECOND_W-1:0] second,
                                   logic [acps_pkg::CODE_W-1:0] flags);
            pair_choice_t exp;
            if (pending_q.size() == 0) begin
                $error("result word with nothing pending: first_pair %0d", first);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            checked++;
            codes_seen[exp.flags] = 1'b1;
            if (first !== exp.first) begin
                $error("first_pair: expected %0d, actual %0d", exp.first, first);
                errors++;
            end
            if (second !== exp.second) begin
                $error("second_pair: expected %0d, actual %0d", exp.second, second);
                errors++;
            end
            if (flags !== exp.flags) begin
                $error("cross_bits: expected %b, actual %b", exp.flags, flags);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_ready;
    logic                          region;
    logic                          best_anode_valid;
    logic [acps_pkg::WIRE_W-1:0]   best_anode_wire;
    logic                          second_anode_valid;
    logic [acps_pkg::WIRE_W-1:0]   second_anode_wire;
    logic                          second_anode_duplicate;
    logic                          best_cathode_valid;
    logic [acps_pkg::HS_W-1:0]     best_cathode_halfstrip;
    logic                          second_cathode_valid;
    logic [acps_pkg::HS_W-1:0]     second_cathode_halfstrip;
    logic                          second_cathode_duplicate;
    logic                          result_valid;
    logic                          result_ready;
    logic [acps_pkg::FIRST_W-1:0]  first_pair;
    logic [acps_pkg::SECOND_W-1:0] second_pair;
    logic [acps_pkg::CODE_W-1:0]   cross_bits;

    // Set during a long stretch where neither side idles.
    logic                no_idle;
    int                  words_sent;

    pair_scoreboard sb = new();

    anode_cathode_pair_selector uut
    (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .item_valid               (item_valid),
        .item_ready               (item_ready),
        .region                   (region),
        .best_anode_valid         (best_anode_valid),
        .best_anode_wire          (best_anode_wire),
        .second_anode_valid       (second_anode_valid),
        .second_anode_wire        (second_anode_wire),
        .second_anode_duplicate   (second_anode_duplicate),
        .best_cathode_valid       (best_cathode_valid),
        .best_cathode_halfstrip   (best_cathode_halfstrip),
        .second_cathode_valid     (second_cathode_valid),
        .second_cathode_halfstrip (second_cathode_halfstrip),
        .second_cathode_duplicate (second_cathode_duplicate),
        .result_valid             (result_valid),
        .result_ready             (result_ready),
        .first_pair               (first_pair),
        .second_pair              (second_pair),
        .cross_bits               (cross_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Build a candidate word from its fields, in port order.
    function automatic cand_word_t cw(logic rgn, logic ba, int bw, logic sa, int sw,
                                      logic sad, logic bc, int bh, logic sc, int sh,
                                      logic scd);
        cand_word_t w;
        w.region                   = rgn;
        w.best_anode_valid         = ba;
        w.best_anode_wire          = acps_pkg::WIRE_W'(bw);
        w.second_anode_valid       = sa;
        w.second_anode_wire        = acps_pkg::WIRE_W'(sw);
        w.second_anode_duplicate   = sad;
        w.best_cathode_valid       = bc;
        w.best_cathode_halfstrip   = acps_pkg::HS_W'(bh);
        w.second_cathode_valid     = sc;
        w.second_cathode_halfstrip = acps_pkg::HS_W'(sh);
        w.second_cathode_duplicate = scd;
        return w;
    endfunction

    // One random bit.
    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Pick a wire group that has a range in the given region.
    function automatic logic [acps_pkg::WIRE_W-1:0] pick_wire(logic rgn);
        if (rgn == acps_pkg::REGION_1A)
            return acps_pkg::WIRE_W'($urandom_range(0, 15));
        return acps_pkg::WIRE_W'($urandom_range(10, 47));
    endfunction

    // Pick a half-strip that tends to sit on an edge of the wire's window.
    function automatic logic [acps_pkg::HS_W-1:0] pick_halfstrip(
        logic rgn, logic [acps_pkg::WIRE_W-1:0] wg);
        int lo;
        int hi;
        int v;
        if (!pair_scoreboard::hs_window(rgn, wg, lo, hi))
            return acps_pkg::HS_W'($urandom);
        case ($urandom_range(0, 3))
            0:       v = lo + int'($urandom_range(0, 4)) - 2;
            1:       v = hi + int'($urandom_range(0, 4)) - 2;
            2:       v = int'($urandom_range(lo, hi));
            default: v = int'($urandom_range(0, 127));
        endcase
        // Wrap below zero and above the top, both legal half-strips.
        return acps_pkg::HS_W'(v);
    endfunction

    // Mostly geometry-aware candidate sets, some raw noise.
    function automatic cand_word_t make_word();
        cand_word_t w;
        logic       use_best;
        if ($urandom_range(0, 99) < 20)
        begin
            return cw(coin(), coin(), int'($urandom_range(0, 63)),
                      coin(), int'($urandom_range(0, 63)), coin(),
                      coin(), int'($urandom_range(0, 127)), coin(),
                      int'($urandom_range(0, 127)), coin());
        end
        w.region                   = coin();
        w.best_anode_wire          = pick_wire(w.region);
        w.second_anode_wire        = pick_wire(w.region);
        w.best_anode_valid         = $urandom_range(0, 99) < 85;
        w.second_anode_valid       = $urandom_range(0, 99) < 85;
        w.best_cathode_valid       = $urandom_range(0, 99) < 85;
        w.second_cathode_valid     = $urandom_range(0, 99) < 85;
        w.second_anode_duplicate   = $urandom_range(0, 99) < 12;
        w.second_cathode_duplicate = $urandom_range(0, 99) < 12;
        use_best = coin();
        w.best_cathode_halfstrip = pick_halfstrip(w.region,
            use_best ? w.best_anode_wire : w.second_anode_wire);
        use_best = coin();
        w.second_cathode_halfstrip = pick_halfstrip(w.region,
            use_best ? w.best_anode_wire : w.second_anode_wire);
        return w;
    endfunction

    // Offer one word, idling at random first; return at the accepting edge.
    task automatic push_word(cand_word_t w);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid               <= 1'b1;
        region                   <= w.region;
        best_anode_valid         <= w.best_anode_valid;
        best_anode_wire          <= w.best_anode_wire;
        second_anode_valid       <= w.second_anode_valid;
        second_anode_wire        <= w.second_anode_wire;
        second_anode_duplicate   <= w.second_anode_duplicate;
        best_cathode_valid       <= w.best_cathode_valid;
        best_cathode_halfstrip   <= w.best_cathode_halfstrip;
        second_cathode_valid     <= w.second_cathode_valid;
        second_cathode_halfstrip <= w.second_cathode_halfstrip;
        second_cathode_duplicate <= w.second_cathode_duplicate;
        // Hold valid and payload until the block takes the word.
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, directed words, then the random run.
    initial
    begin
        cand_word_t plan[$];

        rst_n                    <= 1'b0;
        item_valid               <= 1'b0;
        region                   <= acps_pkg::REGION_1A;
        best_anode_valid         <= 1'b0;
        best_anode_wire          <= '0;
        second_anode_valid       <= 1'b0;
        second_anode_wire        <= '0;
        second_anode_duplicate   <= 1'b0;
        best_cathode_valid       <= 1'b0;
        best_cathode_halfstrip   <= '0;
        second_cathode_valid     <= 1'b0;
        second_cathode_halfstrip <= '0;
        second_cathode_duplicate <= 1'b0;
        no_idle                  <= 1'b0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing valid, then every field at its top value.
        plan = {plan, cw(acps_pkg::REGION_1A, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 63, 1, 63, 1, 1, 127, 1, 127, 1)};
        // Best pair only, at the lowest wire group and half-strip.
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0)};
        // Inner part: upper edges of the short wire groups, in and just out.
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 15, 1, 14, 0, 1, 22, 1, 23, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 12, 1, 13, 0, 1, 77, 1, 61, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 12, 1, 13, 0, 1, 78, 1, 62, 0)};
        // Outer part: lower edges at the low wire groups, upper at the high.
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 10, 1, 10, 0, 1, 100, 1, 99, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 47, 1, 46, 0, 1, 63, 1, 64, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 44, 1, 45, 0, 1, 105, 1, 93, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 44, 1, 45, 0, 1, 106, 1, 94, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 11, 1, 12, 0, 1, 73, 1, 46, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 11, 1, 13, 0, 1, 72, 1, 22, 0)};
        // Duplicate flags knock out otherwise crossing second candidates.
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 5, 1, 6, 1, 1, 50, 1, 60, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 5, 1, 6, 0, 1, 50, 1, 60, 1)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 5, 1, 6, 1, 1, 50, 1, 60, 1)};
        // Wire groups past the table, and ones without a range.
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 48, 1, 63, 0, 1, 0, 1, 10, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 48, 1, 63, 0, 1, 0, 1, 10, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 16, 1, 47, 0, 1, 5, 1, 10, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 0, 1, 9, 0, 1, 120, 1, 127, 0)};
        // Single second-anode crossings and mixed patterns of the choice table.
        plan = {plan, cw(acps_pkg::REGION_1A, 0, 0, 1, 3, 0, 0, 50, 1, 20, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 0, 0, 1, 3, 0, 1, 50, 0, 0, 0)};
        plan = {plan, cw(acps_pkg::REGION_1A, 1, 15, 1, 14, 0, 1, 90, 1, 10, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 10, 1, 47, 0, 1, 50, 1, 110, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 20, 1, 47, 0, 1, 50, 1, 110, 0)};
        plan = {plan, cw(acps_pkg::REGION_1B, 1, 10, 1, 47, 0, 1, 110, 1, 50, 0)};
        foreach (plan[i])
            push_word(plan[i]);
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 600)
                no_idle <= 1'b1;
            if (i == 900)
                no_idle <= 1'b0;
            // Hold off once mid-run until the pipeline is empty.
            if (i == 1100)
                drain_results();
            push_word(make_word());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words over both regions, checked %0d results;",
                 words_sent, sb.checked);
        $display("crossing patterns exercised: %0d of 16.", $countones(sb.codes_seen));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: check each accepted result word, stall at random.
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_valid && result_ready)
                    sb.check_result(first_pair, second_pair, cross_bits);
                result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
